>>> sv/length_prefix_deframer_core_defines.svh
// ----------------------------------------------------------------------------
// length_prefix_deframer_core_defines
// assertion macros shared by the deframer checker
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIX_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// shared constants and types of the length-prefix deframer
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int PREFIX_BYTES = 4;
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = BYTE_W * PREFIX_BYTES;
  localparam int CFG_LEN_W    = 31;
  localparam int CMP_W        = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
  localparam int CNT_W        = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  localparam logic [CNT_W-1:0]     LAST_CNT  = CNT_W'(PREFIX_BYTES - 1);
  localparam logic [CFG_LEN_W-1:0] MIN_RESET = CFG_LEN_W'(1);
  localparam logic [CFG_LEN_W-1:0] MAX_RESET = CFG_LEN_W'(65536);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DEAD    = 3'b100
  } phase_t;

  typedef enum logic [0:0] {
    REG_MIN_LENGTH = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } reg_idx_t;

endpackage

>>> sv/lpd_if.sv
// ----------------------------------------------------------------------------
// lpd_if
// valid/ready channels of the deframer: byte input and result output
// ----------------------------------------------------------------------------
interface lpd_in_if import lpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpd_out_if import lpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic              last;
  logic              bad_length;

  modport source (output valid, output payload_byte, output last, output bad_length,
                  input ready);
  modport sink   (input valid, input payload_byte, input last, input bad_length,
                  output ready);
endinterface

>>> sv/length_prefix_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_core
// splits a byte stream into length-prefixed packets
// ----------------------------------------------------------------------------
// in_chan takes one stream byte per word. each packet opens with a
// little-endian signed length prefix (PREFIX_BYTES bytes); prefix bytes give
// no word on out_chan. a length within [min_length, max_length] passes the
// following bytes out as payload words, last set on the final one. a length
// outside the bounds gives one word with bad_length set; all later bytes are
// then taken and dropped until reset.
// throughput: one byte per cycle while the result register is not stalled. a
// result word passes the input register, then the result register.
// when out_chan stalls the result register holds; the input register takes a
// byte only while it is empty or the result register is being freed, so a
// prefix or dropped byte also waits behind a stalled result word.
// reset: bounds return to 1 and 65536, prefix collection restarts, both
// registers empty. min_length at 0x0, max_length at 0x4 over the APB port; the
// user must write them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module length_prefix_deframer_core import lpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lpd_in_if.sink                in_chan,
  lpd_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_LEN_W-1:0] min_len_r;
  logic [CFG_LEN_W-1:0] max_len_r;

  logic                 s1_valid_r;
  logic [BYTE_W-1:0]    s1_byte_r;

  phase_t               phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [LEN_W-1:0]     acc_r, acc_nxt;
  logic [CFG_LEN_W-1:0] rem_r, rem_nxt;

  logic                 out_valid_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 out_last_r;
  logic                 out_bad_r;

  logic                 out_free;
  logic                 s1_go;
  logic                 emit;
  logic [BYTE_W-1:0]    emit_byte;
  logic                 emit_last;
  logic                 emit_bad;
  logic [LEN_W-1:0]     acc_cur;
  logic [CMP_W-1:0]     len_ext;
  logic                 len_bad;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_MIN_LENGTH: prdata = APB_DATA_W'(min_len_r);
      REG_MAX_LENGTH: prdata = APB_DATA_W'(max_len_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_RESET;
      max_len_r <= MAX_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MIN_LENGTH: min_len_r <= pwdata[CFG_LEN_W-1:0];
        REG_MAX_LENGTH: max_len_r <= pwdata[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_go         = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.data_byte;
    end
  end

  // prefix accumulate and bounds check
  always_comb begin
    acc_cur = acc_r;
    for (int i = 0; i < PREFIX_BYTES; i++) begin
      if (cnt_r == CNT_W'(i)) begin
        acc_cur[BYTE_W*i +: BYTE_W] = s1_byte_r;
      end
    end
  end

  assign len_ext = CMP_W'(acc_cur);
  assign len_bad = acc_cur[LEN_W-1] || (len_ext < CMP_W'(min_len_r))
                   || (len_ext > CMP_W'(max_len_r));

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    emit      = 1'b0;
    emit_byte = s1_byte_r;
    emit_last = 1'b0;
    emit_bad  = 1'b0;
    case (phase_r)
      PH_HEADER: begin
        if (cnt_r == LAST_CNT) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          if (len_bad) begin
            phase_nxt = PH_DEAD;
            rem_nxt   = '0;
            emit      = 1'b1;
            emit_byte = '0;
            emit_bad  = 1'b1;
          end else begin
            rem_nxt   = len_ext[CFG_LEN_W-1:0];
            phase_nxt = (len_ext[CFG_LEN_W-1:0] != '0) ? PH_PAYLOAD : PH_HEADER;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          acc_nxt = acc_cur;
        end
      end
      PH_PAYLOAD: begin
        emit      = 1'b1;
        emit_last = (rem_r <= CFG_LEN_W'(1));
        if (emit_last) begin
          rem_nxt   = '0;
          phase_nxt = PH_HEADER;
        end else begin
          rem_nxt = rem_r - CFG_LEN_W'(1);
        end
      end
      PH_DEAD: ;
      default: phase_nxt = PH_DEAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
    end else if (s1_go) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
      out_bad_r  <= emit_bad;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.payload_byte = out_byte_r;
  assign out_chan.last         = out_last_r;
  assign out_chan.bad_length   = out_bad_r;

endmodule

>>> sv/lpd_checker.sv
// ----------------------------------------------------------------------------
// lpd_checker
// port-level assertions on the deframer result channel
// ----------------------------------------------------------------------------
`include "length_prefix_deframer_core_defines.svh"

module lpd_checker import lpd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_payload_byte,
  input logic              out_last,
  input logic              out_bad_length
);

  `LPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload_byte) && $stable(out_last) && $stable(out_bad_length), "stalled result word changed")
  `LPD_ASSERT_NOW(a_bad_clean, out_valid && out_bad_length, !out_last && (out_payload_byte == '0), "bad-length word carries payload or last")
  `LPD_ASSERT_NEXT(a_dead_quiet, out_valid && out_ready && out_bad_length, !out_valid, "word after bad-length result")

endmodule

bind length_prefix_deframer_core lpd_checker u_lpd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_payload_byte (out_chan.payload_byte),
  .out_last         (out_chan.last),
  .out_bad_length   (out_chan.bad_length)
);
